@@ src/keyframe_track_sampler_blend_defines.svh @@
// Assertion macros used by the checker file of the keyframe sampler.
`ifndef KEYFRAME_TRACK_SAMPLER_BLEND_DEFINES_SVH
`define KEYFRAME_TRACK_SAMPLER_BLEND_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define KTSB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyframe sampler check failed");

// Consequence must hold in the cycle after the antecedent.
`define KTSB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyframe sampler check failed");

`endif

@@ src/ktsb_pkg.sv @@
package ktsb_pkg;

   localparam int DEF_KEYS_PER_TRACK = 64;
   localparam int NUM_TRACKS         = 2;
   localparam int TRACK_W            = $clog2(NUM_TRACKS);

   localparam int KIND_W    = 2;
   localparam int INDEX_W   = 6;
   localparam int TIME_W    = 32;
   localparam int VAL_W     = 32;
   localparam int FRAC_W    = 16;
   localparam int FAC_W     = FRAC_W + 1;
   localparam int COUNT_W   = 7;
   localparam int NUM_COMPS = 3;
   localparam int COMP_W    = 2;
   localparam int PROD_W    = (VAL_W + 1) + (FAC_W + 1);

   // Restoring division yields one quotient bit per step.
   localparam int DIV_STEPS = FAC_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [FAC_W-1:0] ONE_Q16 = FAC_W'(1) << FRAC_W;

   // Request payload layout.
   localparam int OFF_KEY_INDEX = 0;
   localparam int OFF_TIME      = OFF_KEY_INDEX + INDEX_W;
   localparam int OFF_TO_TIME   = OFF_TIME + TIME_W;
   localparam int OFF_VALUE     = OFF_TO_TIME + TIME_W;
   localparam int OFF_FACTOR    = OFF_VALUE + NUM_COMPS * VAL_W;
   localparam int REQ_BITS      = OFF_FACTOR + FAC_W;
   localparam int REQ_TDATA_W   = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_W   = KIND_W + TRACK_W;
   localparam int RSP_TDATA_W   = NUM_COMPS * VAL_W;

   localparam int CSR_INDEX_W = 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_BLEND  = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KEY_COUNT_A = 1'b0,
      REG_KEY_COUNT_B = 1'b1
   } csr_reg_type;

   typedef logic [NUM_COMPS-1:0][VAL_W-1:0] vec_type;

   // Operand source for the lerp unit.
   typedef enum logic [1:0] {
      OP_CUR   = 2'd0,
      OP_SEG   = 2'd1,
      OP_BLEND = 2'd2
   } op_sel_type;

   typedef struct packed {
      logic               capture;
      logic               mem_write;
      logic               rd_en;
      logic [TRACK_W-1:0] rd_track;
      logic               use_to_time;
      logic               load_prev;
      logic               op_load;
      op_sel_type         op_sel;
      logic               div_init;
      logic               div_step;
      logic               fac_load;
      logic               mul_en;
      logic               add_en;
      logic [COMP_W-1:0]  comp;
      logic               hold_load;
      logic               rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic le_first;
      logic seg_hit;
   } dp_status_type;

endpackage

@@ src/ktsb_datapath.sv @@
module ktsb_datapath #(
   parameter int KEYS_PER_TRACK = ktsb_pkg::DEF_KEYS_PER_TRACK
) (
   input  logic                                clock,
   input  logic [ktsb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [ktsb_pkg::TRACK_W-1:0]        req_track,
   input  ktsb_pkg::ctrl_cmd_type              cmd,
   input  logic [$clog2(KEYS_PER_TRACK)-1:0]   rd_slot,
   output ktsb_pkg::dp_status_type             status,
   output logic [ktsb_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import ktsb_pkg::*;

   localparam int SLOT_W    = $clog2(KEYS_PER_TRACK);
   localparam int ADDR_W    = TRACK_W + SLOT_W;
   localparam int DEPTH     = NUM_TRACKS << SLOT_W;
   localparam int IDX_EXT_W = SLOT_W + INDEX_W;

   logic [INDEX_W-1:0]   key_index;
   logic [IDX_EXT_W-1:0] idx_ext;
   logic                 in_range;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ADDR_W-1:0]    rd_addr;
   logic [TIME_W-1:0]    wr_time;
   vec_type              wr_val;
   logic [FAC_W-1:0]     req_factor;

   logic [TIME_W-1:0] time_mem [DEPTH];
   vec_type           val_mem  [DEPTH];

   logic [TIME_W-1:0] rd_time_ff;
   vec_type           rd_val_ff;
   logic [TIME_W-1:0] prev_time_ff;
   vec_type           prev_val_ff;
   logic [TIME_W-1:0] tp_ff;
   logic [TIME_W-1:0] tt_ff;
   logic [FAC_W-1:0]  bf_ff;
   logic [TIME_W-1:0] t_sel;

   vec_type           op_a_ff;
   vec_type           op_b_ff;
   logic [FAC_W-1:0]  fac_ff;
   vec_type           res_ff;
   vec_type           hold_ff;
   vec_type           rsp_ff;

   logic [TIME_W-1:0]    rem_ff;
   logic [TIME_W-1:0]    rem_in;
   logic [TIME_W-1:0]    den_ff;
   logic [DIV_STEPS-1:0] nb_ff;
   logic [DIV_STEPS-1:0] q_ff;
   logic [DIV_STEPS-1:0] q_in;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      trial_diff;
   logic                 trial_ge;
   logic [TIME_W-1:0]    num_d;

   logic signed [VAL_W:0]    diff_w;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] sum_w;

   assign key_index  = req_tdata[OFF_KEY_INDEX +: INDEX_W];
   assign idx_ext    = IDX_EXT_W'(key_index);
   assign in_range   = idx_ext < IDX_EXT_W'(KEYS_PER_TRACK);
   assign wr_addr    = {req_track, idx_ext[SLOT_W-1:0]};
   assign rd_addr    = {cmd.rd_track, rd_slot};
   assign wr_time    = req_tdata[OFF_TIME +: TIME_W];
   assign wr_val     = req_tdata[OFF_VALUE +: NUM_COMPS * VAL_W];
   assign req_factor = req_tdata[OFF_FACTOR +: FAC_W];

   always_ff @(posedge clock) begin
      if (cmd.mem_write && in_range) begin
         time_mem[wr_addr] <= wr_time;
         val_mem[wr_addr]  <= wr_val;
      end
      if (cmd.rd_en) begin
         rd_time_ff <= time_mem[rd_addr];
         rd_val_ff  <= val_mem[rd_addr];
      end
   end

   assign t_sel           = cmd.use_to_time ? tt_ff : tp_ff;
   assign status.le_first = t_sel <= rd_time_ff;
   assign status.seg_hit  = (prev_time_ff <= t_sel) && (t_sel <= rd_time_ff);

   // Fraction divider: (t - t0) << 16 over (t1 - t0). The top 31 numerator
   // bits cannot produce a quotient bit, so the remainder starts preloaded.
   assign num_d      = t_sel - prev_time_ff;
   assign trial      = {rem_ff, nb_ff[DIV_STEPS-1]};
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};
   assign rem_in     = trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
   assign q_in       = {q_ff[DIV_STEPS-2:0], trial_ge};

   // Lerp: a + floor((b - a) * f / 65536), one component at a time.
   assign diff_w = $signed({op_b_ff[cmd.comp][VAL_W-1], op_b_ff[cmd.comp]})
                 - $signed({op_a_ff[cmd.comp][VAL_W-1], op_a_ff[cmd.comp]});
   assign sum_w  = PROD_W'($signed(op_a_ff[cmd.comp])) + (prod_ff >>> FRAC_W);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tp_ff <= wr_time;
         tt_ff <= req_tdata[OFF_TO_TIME +: TIME_W];
         bf_ff <= (req_factor > ONE_Q16) ? ONE_Q16 : req_factor;
      end
      if (cmd.load_prev) begin
         prev_time_ff <= rd_time_ff;
         prev_val_ff  <= rd_val_ff;
      end
      if (cmd.op_load) begin
         unique case (cmd.op_sel)
            OP_CUR: begin
               op_a_ff <= rd_val_ff;
               op_b_ff <= rd_val_ff;
               fac_ff  <= '0;
            end
            OP_SEG: begin
               op_a_ff <= prev_val_ff;
               op_b_ff <= rd_val_ff;
            end
            OP_BLEND: begin
               op_a_ff <= hold_ff;
               op_b_ff <= res_ff;
               fac_ff  <= bf_ff;
            end
            default: begin
               op_a_ff <= rd_val_ff;
               op_b_ff <= rd_val_ff;
               fac_ff  <= '0;
            end
         endcase
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, num_d[TIME_W-1:1]};
         nb_ff  <= {num_d[0], {(DIV_STEPS-1){1'b0}}};
         den_ff <= rd_time_ff - prev_time_ff;
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         nb_ff  <= nb_ff << 1;
         q_ff   <= q_in;
      end
      // A zero-length segment repairs the 0/0 by taking its first key.
      if (cmd.fac_load) begin
         fac_ff <= (den_ff == '0) ? '0 : q_ff;
      end
      if (cmd.mul_en) begin
         prod_ff <= diff_w * $signed({1'b0, fac_ff});
      end
      if (cmd.add_en) begin
         res_ff[cmd.comp] <= sum_w[VAL_W-1:0];
      end
      if (cmd.hold_load) begin
         hold_ff <= res_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

@@ src/ktsb_ctrl.sv @@
module ktsb_ctrl #(
   parameter int KEYS_PER_TRACK = ktsb_pkg::DEF_KEYS_PER_TRACK
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ktsb_pkg::KIND_W-1:0]         req_kind,
   input  logic [ktsb_pkg::TRACK_W-1:0]        req_track,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [ktsb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ktsb_pkg::COUNT_W-1:0]        csr_wdata,
   output ktsb_pkg::ctrl_cmd_type              cmd,
   output logic [$clog2(KEYS_PER_TRACK)-1:0]   rd_slot,
   input  ktsb_pkg::dp_status_type             status
);
   import ktsb_pkg::*;

   localparam int SLOT_W    = $clog2(KEYS_PER_TRACK);
   localparam int KEY_W     = SLOT_W + 1;
   localparam int CNT_EXT_W = SLOT_W + COUNT_W + 1;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_RD0  = 10'b00_0000_0010,
      ST_CHK0 = 10'b00_0000_0100,
      ST_SCAN = 10'b00_0000_1000,
      ST_DIV  = 10'b00_0001_0000,
      ST_FAC  = 10'b00_0010_0000,
      ST_MUL  = 10'b00_0100_0000,
      ST_ADD  = 10'b00_1000_0000,
      ST_NEXT = 10'b01_0000_0000,
      ST_OUT  = 10'b10_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      JOB_SINGLE  = 2'd0,
      JOB_BLEND_A = 2'd1,
      JOB_BLEND_B = 2'd2,
      JOB_MIX     = 2'd3
   } job_type;

   state_type            state_ff, state_in;
   job_type              job_ff, job_in;
   logic [TRACK_W-1:0]   trk_ff, trk_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [COMP_W-1:0]    comp_ff, comp_in;
   logic [COUNT_W-1:0]   count_a_ff, count_b_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [COUNT_W-1:0]   count_sel;
   logic [CNT_EXT_W-1:0] cnt_ext;
   logic [CNT_EXT_W-1:0] n_ext;
   logic [KEY_W-1:0]     n_keys;
   logic                 at_last;
   logic                 accept;
   logic                 rsp_free;

   // Key count in use, with zero read as one and overflow as full.
   assign count_sel = (trk_ff == '0) ? count_a_ff : count_b_ff;
   assign cnt_ext   = CNT_EXT_W'(count_sel);
   assign n_ext     = (cnt_ext == '0) ? CNT_EXT_W'(1) :
                      (cnt_ext > CNT_EXT_W'(KEYS_PER_TRACK)) ? CNT_EXT_W'(KEYS_PER_TRACK) :
                      cnt_ext;
   assign n_keys    = n_ext[KEY_W-1:0];
   assign at_last   = key_ff == (n_keys - KEY_W'(1));

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rd_slot    = key_in[SLOT_W-1:0];

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      trk_in     = trk_ff;
      key_in     = key_ff;
      div_cnt_in = div_cnt_ff;
      comp_in    = comp_ff;

      cmd             = '0;
      cmd.rd_track    = trk_ff;
      cmd.use_to_time = job_ff == JOB_BLEND_B;
      cmd.comp        = comp_ff;
      cmd.op_sel      = OP_CUR;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (kind_type'(req_kind))
                  KIND_WRITE: begin
                     cmd.mem_write = 1'b1;
                  end
                  KIND_SAMPLE: begin
                     job_in   = JOB_SINGLE;
                     trk_in   = req_track;
                     state_in = ST_RD0;
                  end
                  KIND_BLEND: begin
                     job_in   = JOB_BLEND_A;
                     trk_in   = '0;
                     state_in = ST_RD0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RD0: begin
            cmd.rd_en = 1'b1;
            key_in    = '0;
            state_in  = ST_CHK0;
         end
         ST_CHK0: begin
            cmd.load_prev = 1'b1;
            if ((n_keys == KEY_W'(1)) || status.le_first) begin
               cmd.op_load = 1'b1;
               cmd.op_sel  = OP_CUR;
               comp_in     = '0;
               state_in    = ST_MUL;
            end else begin
               cmd.rd_en = 1'b1;
               key_in    = KEY_W'(1);
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.seg_hit) begin
               cmd.op_load  = 1'b1;
               cmd.op_sel   = OP_SEG;
               cmd.div_init = 1'b1;
               div_cnt_in   = '0;
               state_in     = ST_DIV;
            end else if (at_last) begin
               cmd.op_load = 1'b1;
               cmd.op_sel  = OP_CUR;
               comp_in     = '0;
               state_in    = ST_MUL;
            end else begin
               cmd.load_prev = 1'b1;
               cmd.rd_en     = 1'b1;
               key_in        = key_ff + KEY_W'(1);
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FAC;
            end else begin
               div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            end
         end
         ST_FAC: begin
            cmd.fac_load = 1'b1;
            comp_in      = '0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_en = 1'b1;
            if (comp_ff == COMP_W'(NUM_COMPS - 1)) begin
               state_in = ST_NEXT;
            end else begin
               comp_in  = comp_ff + COMP_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_NEXT: begin
            unique case (job_ff)
               JOB_BLEND_A: begin
                  cmd.hold_load = 1'b1;
                  trk_in        = TRACK_W'(1);
                  job_in        = JOB_BLEND_B;
                  state_in      = ST_RD0;
               end
               JOB_BLEND_B: begin
                  cmd.op_load = 1'b1;
                  cmd.op_sel  = OP_BLEND;
                  job_in      = JOB_MIX;
                  comp_in     = '0;
                  state_in    = ST_MUL;
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_a_ff   <= COUNT_W'(1);
         count_b_ff   <= COUNT_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_reg_type'(csr_index))
               REG_KEY_COUNT_A: count_a_ff <= csr_wdata;
               REG_KEY_COUNT_B: count_b_ff <= csr_wdata;
               default: begin
                  count_a_ff <= count_a_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      trk_ff     <= trk_in;
      key_ff     <= key_in;
      div_cnt_ff <= div_cnt_in;
      comp_ff    <= comp_in;
   end

endmodule

@@ src/keyframe_track_sampler_blend.sv @@
// Keyframe track sampler with blend. Two tracks, A and B, each hold up to
// KEYS_PER_TRACK keys of a Q16.16 time and a signed Q16.16 3-vector value.
// Request beats arrive on req_*: kind 0 writes a key (no response),
// kind 1 samples one track at time_point, kind 2 samples A at time_point and
// B at to_time and mixes them by blend_factor. Each sample or blend produces
// one response beat on rsp_* with the x, y and z result.
// A track sample reads key 0; unless that key answers, it walks the keys one
// per cycle through the key memory read port until a segment brackets the
// time or the last key is reached, and for a segment runs a 17-step
// restoring divider for the segment fraction. It then lerps the three
// components one at a time on a shared multiplier. The request side accepts
// one sample or blend at a time; writes are taken every cycle while idle. The
// result sits in an output register, so a new request is accepted while an
// earlier result waits; if the receiver still stalls when the next result is
// ready, the block holds in place until the response beat is taken. Reset
// sets both key counts to one and clears the handshakes; key memory contents
// are undefined until written.
module keyframe_track_sampler_blend #(
   parameter int KEYS_PER_TRACK = ktsb_pkg::DEF_KEYS_PER_TRACK
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // key_index, time_point, to_time, value_x, value_y, value_z, blend_factor
   input  logic [ktsb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // kind, track
   input  logic [ktsb_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_z
   output logic [ktsb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [ktsb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ktsb_pkg::COUNT_W-1:0]      csr_wdata
);
   import ktsb_pkg::*;

   ctrl_cmd_type                      cmd;
   dp_status_type                     status;
   logic [$clog2(KEYS_PER_TRACK)-1:0] rd_slot;
   logic [KIND_W-1:0]                 req_kind;
   logic [TRACK_W-1:0]                req_track;

   // The kind sits in the low bits of tuser, the track select above it.
   assign req_kind  = req_tuser[KIND_W-1:0];
   assign req_track = req_tuser[KIND_W +: TRACK_W];

   // Sequencer: handshakes, key counts, scan, divide and lerp steps.
   ktsb_ctrl #(
      .KEYS_PER_TRACK (KEYS_PER_TRACK)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind),
      .req_track  (req_track),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .rd_slot    (rd_slot),
      .status     (status)
   );

   // Key memories, time compares, divider, multiplier and output register.
   ktsb_datapath #(
      .KEYS_PER_TRACK (KEYS_PER_TRACK)
   ) u_datapath (
      .clock     (clock),
      .req_tdata (req_tdata),
      .req_track (req_track),
      .cmd       (cmd),
      .rd_slot   (rd_slot),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ src/ktsb_checker.sv @@
`include "keyframe_track_sampler_blend_defines.svh"

module ktsb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [ktsb_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ktsb_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import ktsb_pkg::*;

   logic req_beat;
   logic req_is_query;

   assign req_beat     = req_tvalid && req_tready;
   assign req_is_query = (req_tuser[KIND_W-1:0] == KIND_SAMPLE)
                      || (req_tuser[KIND_W-1:0] == KIND_BLEND);

   // A stalled response beat keeps its payload.
   `KTSB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // A sample or blend occupies the block for at least the next cycle.
   `KTSB_ASSERT_NEXT(a_query_busy, req_beat && req_is_query, !req_tready)

   // Key writes and unknown kinds never block the request side.
   `KTSB_ASSERT_NEXT(a_write_ready, req_beat && !req_is_query, req_tready)

   // A new response only appears after a busy cycle on the request side.
   `KTSB_ASSERT_SAME(a_rsp_after_busy, $rose(rsp_tvalid), $past(!req_tready))

endmodule

bind keyframe_track_sampler_blend ktsb_checker u_ktsb_checker (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the keyframe sampler. Key writes, single-track
// samples, A-to-B blends and unused-kind beats go in on req_*, and every
// response beat on rsp_* is checked against a local model of both tracks.
module testbench;
   import ktsb_pkg::*;

   localparam int KEYS = DEF_KEYS_PER_TRACK;
   localparam int PHASES = 8;
   localparam int RANDOM_PER_PHASE = 20;
   // This pause covers any write or unused-kind beat that may still be in the block.
   localparam int SETTLE_CYCLES = 250;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum {SHAPE_SORTED, SHAPE_SPAN, SHAPE_UNSORTED} track_shape_type;

   // One request beat before it is packed onto req_tdata and req_tuser.
   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic               trk;
      logic [INDEX_W-1:0] slot;
      logic [TIME_W-1:0]  at_time;
      logic [TIME_W-1:0]  to_time;
      vec_type            vec;
      logic [FAC_W-1:0]   factor;
   } key_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COUNT_W-1:0]     csr_wdata = '0;

   // Beats waiting to be driven, filled by the stimulus process.
   key_req_type pending [$];
   key_req_type req_cur;

   // Local copy of the block's state: key store and key count registers.
   logic [TIME_W-1:0]  key_time_mem [2*KEYS];
   vec_type            key_vec_mem [2*KEYS];
   logic [COUNT_W-1:0] count_a_reg = 7'd1;
   logic [COUNT_W-1:0] count_b_reg = 7'd1;

   // Key times as planned by the stimulus, used only to aim sample times.
   logic [TIME_W-1:0] plan_time [2*KEYS];

   // Predicted output vectors, oldest first.
   vec_type expected_vecs [$];
   vec_type rsp_want;
   vec_type rsp_got;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int failures = 0;
   int results_checked = 0;
   int writes_taken = 0;
   int samples_taken = 0;
   int blends_taken = 0;
   int unused_taken = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   keyframe_track_sampler_blend DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // A stored count of zero behaves as one key, anything past the track
   // size as a full track.
   function automatic int eff_count(logic [COUNT_W-1:0] c);
      if (c == 0) return 1;
      if (c > KEYS) return KEYS;
      return int'(c);
   endfunction

   // a + floor((b - a) * f / 2^16); the arithmetic shift floors toward minus
   // infinity, and the sum always stays between a and b.
   function automatic logic [VAL_W-1:0] mix_q16(longint a, longint b, longint f);
      longint r;
      r = a + (((b - a) * f) >>> FRAC_W);
      return r[VAL_W-1:0];
   endfunction

   // Value of one track at time t: first key when there is a single key or
   // t is at or before it, else the first bracketing segment, else the last
   // key. A zero-length segment gives its first key.
   function automatic vec_type track_value(logic trk, logic [TIME_W-1:0] t);
      int n, base, i, c;
      longint tl, t0, t1, f;
      vec_type v;
      n = eff_count(trk ? count_b_reg : count_a_reg);
      base = trk ? KEYS : 0;
      tl = longint'(t);
      if (n == 1 || t <= key_time_mem[base]) return key_vec_mem[base];
      for (i = 0; i < n - 1; i++) begin
         t0 = longint'(key_time_mem[base + i]);
         t1 = longint'(key_time_mem[base + i + 1]);
         if (t0 <= tl && tl <= t1) begin
            f = (t1 != t0) ? ((tl - t0) <<< FRAC_W) / (t1 - t0) : 0;
            for (c = 0; c < NUM_COMPS; c++) begin
               v[c] = mix_q16(longint'(signed'(key_vec_mem[base + i][c])),
                              longint'(signed'(key_vec_mem[base + i + 1][c])), f);
            end
            return v;
         end
      end
      return key_vec_mem[base + n - 1];
   endfunction

   // Applies one accepted beat to the local state and queues its result.
   task automatic apply_request(key_req_type r);
      vec_type va, vb, mixed;
      logic [FAC_W-1:0] f;
      int c;
      case (r.kind)
         KIND_WRITE: begin
            key_time_mem[{r.trk, r.slot}] = r.at_time;
            key_vec_mem[{r.trk, r.slot}] = r.vec;
            writes_taken++;
         end
         KIND_SAMPLE: begin
            expected_vecs.insert(expected_vecs.size(), track_value(r.trk, r.at_time));
            samples_taken++;
         end
         KIND_BLEND: begin
            // Factors above one are saturated to fully B.
            f = (r.factor > ONE_Q16) ? ONE_Q16 : r.factor;
            va = track_value(1'b0, r.at_time);
            vb = track_value(1'b1, r.to_time);
            for (c = 0; c < NUM_COMPS; c++) begin
               mixed[c] = mix_q16(longint'(signed'(va[c])), longint'(signed'(vb[c])),
                                  longint'(f));
            end
            expected_vecs.insert(expected_vecs.size(), mixed);
            blends_taken++;
         end
         default: begin
            // The unused kind changes nothing and returns nothing.
            unused_taken++;
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Driver: request side
   // ------------------------------------------------------------------

   // A beat is taken at an edge where valid and ready are both high. The
   // prediction is made on that edge, then the next beat (or a gap) is set up.
   // Valid gets at most one assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(req_cur);
         end
         if (!req_tvalid || req_tready) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_cur = pending.pop_front();
               req_tvalid <= 1'b1;
               // From bit 0 up: key_index, time_point, to_time, value x/y/z,
               // blend_factor, then zero padding to a whole byte.
               req_tdata <= REQ_TDATA_W'({req_cur.factor, req_cur.vec, req_cur.to_time,
                                          req_cur.at_time, req_cur.slot});
               req_tuser <= {req_cur.trk, req_cur.kind};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: response side
   // ------------------------------------------------------------------

   // Each response beat is matched with the oldest prediction, component by
   // component. Ready is randomized per cycle to apply back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_got = rsp_tdata;
            if (expected_vecs.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("ERROR: response beat %h with nothing predicted", rsp_got);
               end
            end else begin
               rsp_want = expected_vecs.pop_front();
               results_checked++;
               for (int c = 0; c < NUM_COMPS; c++) begin
                  if (rsp_got[c] !== rsp_want[c]) begin
                     failures++;
                     if (failures <= 10) begin
                        $display("ERROR: result %0d out_%s expected %h actual %h",
                                 results_checked, (c == 0) ? "x" : (c == 1) ? "y" : "z",
                                 rsp_want[c], rsp_got[c]);
                     end
                  end
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still predicted",
                  cycle_count, expected_vecs.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Fields a kind does not use still carry random bits.
   function automatic key_req_type random_req(logic [KIND_W-1:0] kind, logic trk);
      key_req_type r;
      r.kind = kind;
      r.trk = trk;
      r.slot = INDEX_W'($urandom_range(KEYS - 1));
      r.at_time = $urandom;
      r.to_time = $urandom;
      r.vec = {$urandom, $urandom, $urandom};
      r.factor = FAC_W'($urandom_range(2 * ONE_Q16 - 1));
      return r;
   endfunction

   function automatic vec_type rand_vec();
      vec_type v;
      for (int c = 0; c < NUM_COMPS; c++) begin
         case ($urandom_range(7))
            0: v[c] = 32'h7FFF_FFFF;
            1: v[c] = 32'h8000_0000;
            default: v[c] = $urandom;
         endcase
      end
      return v;
   endfunction

   function automatic logic [FAC_W-1:0] rand_factor();
      case ($urandom_range(7))
         0: return '0;
         1: return ONE_Q16;
         2: return FAC_W'($urandom_range(2 * ONE_Q16 - 1, ONE_Q16 + 1));
         default: return FAC_W'($urandom_range(ONE_Q16));
      endcase
   endfunction

   // Sample times mostly land on or between the keys in use, with the
   // time-axis extremes and fully random times mixed in.
   function automatic logic [TIME_W-1:0] pick_time(logic trk);
      int n, i, base;
      n = eff_count(trk ? count_b_reg : count_a_reg);
      base = trk ? KEYS : 0;
      i = $urandom_range(n - 1);
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return $urandom;
         3, 4: return plan_time[base + i];
         default: begin
            if (i == n - 1) return plan_time[base + i] + $urandom_range(255);
            return $urandom_range(plan_time[base + i + 1], plan_time[base + i]);
         end
      endcase
   endfunction

   task automatic queue_req(key_req_type r);
      if (r.kind == KIND_WRITE) plan_time[{r.trk, r.slot}] = r.at_time;
      pending.insert(pending.size(), r);
   endtask

   task automatic queue_key(logic trk, logic [INDEX_W-1:0] slot, logic [TIME_W-1:0] t,
                            vec_type v);
      key_req_type r;
      r = random_req(KIND_WRITE, trk);
      r.slot = slot;
      r.at_time = t;
      r.vec = v;
      queue_req(r);
   endtask

   task automatic queue_sample(logic trk, logic [TIME_W-1:0] t);
      key_req_type r;
      r = random_req(KIND_SAMPLE, trk);
      r.at_time = t;
      queue_req(r);
   endtask

   task automatic queue_blend(logic [TIME_W-1:0] ta, logic [TIME_W-1:0] tb,
                              logic [FAC_W-1:0] f);
      key_req_type r;
      r = random_req(KIND_BLEND, 1'($urandom_range(1)));
      r.at_time = ta;
      r.to_time = tb;
      r.factor = f;
      queue_req(r);
   endtask

   // Loads all slots of a track. Sorted tracks get some repeated times
   // (always one at slots 1 and 2); the span shape runs from time zero to the
   // largest time; the unsorted shape has random times.
   task automatic load_track(logic trk, track_shape_type shape);
      longint t, step;
      t = (shape == SHAPE_SPAN) ? 0 : $urandom_range(1 << 20);
      step = (shape == SHAPE_SPAN) ? 32'h03FF_FFFF : 32'h003F_FFFF;
      for (int s = 0; s < KEYS; s++) begin
         if (shape == SHAPE_UNSORTED) begin
            t = $urandom;
         end else if (s > 0 && s != 2 && $urandom_range(7) != 0) begin
            t = t + $urandom_range(32'(step));
         end
         if (shape == SHAPE_SPAN && s == KEYS - 1) t = 32'hFFFF_FFFF;
         queue_key(trk, INDEX_W'(s), t[TIME_W-1:0], rand_vec());
      end
   endtask

   // Registers change only when nothing is in flight.
   task automatic write_count(csr_reg_type idx, logic [COUNT_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_KEY_COUNT_A) count_a_reg = value;
      else count_b_reg = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every beat is taken and every result is back, then gives
   // writes and unused-kind beats time to leave the block.
   task automatic drain_and_settle();
      do @(posedge clock);
      while (pending.size() != 0 || req_tvalid || expected_vecs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin
      int cnt_a [PHASES];
      int cnt_b [PHASES];
      int send_pct [4];
      int recv_pct [4];
      int p, k, r, s;
      logic trk;
      logic [TIME_W-1:0] lo, hi, t;
      key_req_type noise;

      // Key counts per phase: zero, one, full, past full and the 7-bit top
      // end, plus one random pair.
      cnt_a = '{64, 0, 127, 1, 65, 2, 33, 0};
      cnt_b = '{64, 127, 0, 64, 2, 65, 7, 0};
      cnt_a[PHASES-1] = $urandom_range(127);
      cnt_b[PHASES-1] = $urandom_range(127);
      send_pct = '{0, 77, 0, 21};
      recv_pct = '{0, 0, 77, 21};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed beats with the reset counts of one key per track: only slot 0
      // is read, and it carries the value extremes.
      queue_key(1'b0, '0, 32'h0001_0000, {32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
      queue_key(1'b1, '0, 32'hFFFF_FFFF, {32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000});
      queue_sample(1'b0, 32'h0000_0000);
      queue_sample(1'b0, 32'hFFFF_FFFF);
      queue_sample(1'b1, 32'h0000_0000);
      queue_sample(1'b1, 32'hFFFF_FFFF);
      queue_blend(32'h0000_0000, 32'hFFFF_FFFF, '0);
      queue_blend(32'h0000_0000, 32'h0000_0000, ONE_Q16);
      queue_blend(32'hFFFF_FFFF, 32'h0000_0000, ONE_Q16 >> 1);
      queue_blend(32'h0001_0000, 32'h0001_0000, '1);
      queue_blend(32'h8000_0000, 32'h7FFF_FFFF, ONE_Q16 + 1);
      noise = random_req(KIND_UNUSED, 1'b1);
      noise.slot = '1;
      noise.at_time = '1;
      noise.to_time = '1;
      noise.vec = '1;
      noise.factor = '1;
      queue_req(noise);
      queue_key(1'b1, INDEX_W'(KEYS - 1), 32'hFFFF_FFFF, '1);

      // Fill both tracks before any count above one is set.
      load_track(1'b0, SHAPE_SPAN);
      load_track(1'b1, SHAPE_SORTED);
      drain_and_settle();

      for (p = 0; p < PHASES; p++) begin
         write_count(REG_KEY_COUNT_A, COUNT_W'(cnt_a[p]));
         write_count(REG_KEY_COUNT_B, COUNT_W'(cnt_b[p]));
         send_idle_pct = send_pct[p % 4];
         recv_stall_pct = recv_pct[p % 4];

         case (p)
            2: load_track(1'b0, SHAPE_UNSORTED);
            5: load_track(1'b0, SHAPE_SORTED);
            default: ;
         endcase

         if (p == 0) begin
            // Full tracks: on the first key, exactly on an inner key, inside a
            // segment, on the last key, before the first key, past the end,
            // and on a repeated key time.
            queue_sample(1'b0, plan_time[0]);
            queue_sample(1'b0, plan_time[5]);
            queue_sample(1'b0, plan_time[10] + (plan_time[11] - plan_time[10]) / 2);
            queue_sample(1'b0, 32'hFFFF_FFFF);
            queue_sample(1'b1, 32'h0000_0000);
            queue_sample(1'b1, 32'hFFFF_FFFF);
            queue_sample(1'b1, plan_time[KEYS + 2]);
            queue_blend(plan_time[20] + 1, plan_time[KEYS + 20] + 1, ONE_Q16 >> 1);
         end

         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            r = $urandom_range(99);
            trk = 1'($urandom_range(1));
            if (r < 15) begin
               // Key rewrites mostly keep the track in order; a few do not.
               s = $urandom_range(KEYS - 1);
               lo = (s == 0) ? '0 : plan_time[{trk, 6'(s - 1)}];
               hi = (s == KEYS - 1) ? '1 : plan_time[{trk, 6'(s + 1)}];
               t = ($urandom_range(9) < 7) ? $urandom_range(hi, lo) : $urandom;
               queue_key(trk, INDEX_W'(s), t, rand_vec());
            end else if (r < 55) begin
               queue_sample(trk, pick_time(trk));
            end else if (r < 95) begin
               queue_blend(pick_time(1'b0), pick_time(1'b1), rand_factor());
            end else begin
               queue_req(random_req(KIND_UNUSED, trk));
            end
         end
         drain_and_settle();
      end

      $display("Covered %0d key writes, %0d track samples, %0d blends and %0d unused-kind beats",
               writes_taken, samples_taken, blends_taken, unused_taken);
      $display("over %0d key-count settings and four idle patterns; %0d results checked.",
               PHASES + 1, results_checked);
      if (failures == 0 && expected_vecs.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d failures, %0d results never arrived", failures, expected_vecs.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
